@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/ibsdp_pkg.sv @@
// Types and constants of the block-scaled int4 x int8 dot product.
`default_nettype none
package ibsdp_pkg;

    localparam int NIBBLE_W    = 4;
    localparam int ACT_W       = 8;
    localparam int WEIGHT_W    = NIBBLE_W + 1;
    localparam int TERM_W      = ACT_W + WEIGHT_W;
    localparam int SUM_W       = 18;
    localparam int SCALE_W     = 16;
    localparam int SCALE_PROD_W = 2 * SCALE_W;
    localparam int PROD_W      = SUM_W + SCALE_PROD_W + 1;
    localparam int ACC_W       = 64;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 64;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic signed [TERM_W-1:0]  term_first;
        logic signed [TERM_W-1:0]  term_second;
        logic        [SCALE_W-1:0] ws_first;
        logic        [SCALE_W-1:0] ws_second;
        logic        [SCALE_W-1:0] as_first;
        logic        [SCALE_W-1:0] as_second;
        logic                      close_group;
        logic                      dot_end;
    } ibsdp_item_t;

    // Queue status seen by the front and the top level.
    typedef struct packed {
        logic empty;
        logic full;
    } ibsdp_q_stat_t;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic busy;
        logic emit_wait;
    } ibsdp_back_stat_t;

endpackage
`default_nettype wire

@@ hdl/ibsdp_front.sv @@
// Front end: unpacks a request, forms the two nibble products and queues them.
`default_nettype none
module ibsdp_front (
    input  wire logic [ibsdp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [0:0]                     s_axis_tuser,
    input  wire logic                           s_axis_tlast,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire ibsdp_pkg::ibsdp_q_stat_t       q_stat,
    output logic                                q_push,
    output ibsdp_pkg::ibsdp_item_t              q_item
);
    import ibsdp_pkg::*;

    logic        [7:0]          weight_byte;
    logic signed [ACT_W-1:0]    act_first;
    logic signed [ACT_W-1:0]    act_second;
    logic        [NIBBLE_W-1:0] zero_first;
    logic        [NIBBLE_W-1:0] zero_second;
    logic signed [WEIGHT_W-1:0] w_first;
    logic signed [WEIGHT_W-1:0] w_second;

    // Field unpacking.
    assign weight_byte = s_axis_tdata[7:0];
    assign act_first   = $signed(s_axis_tdata[15:8]);
    assign act_second  = $signed(s_axis_tdata[23:16]);
    assign zero_first  = s_axis_tdata[91:88];
    assign zero_second = s_axis_tdata[95:92];

    // Weights with their zero points removed, range -15..15.
    assign w_first  = $signed({1'b0, weight_byte[NIBBLE_W-1:0]}) - $signed({1'b0, zero_first});
    assign w_second = $signed({1'b0, weight_byte[7:NIBBLE_W]}) - $signed({1'b0, zero_second});

    // Queue entry: products, scales and the closing flags.
    always_comb begin
        q_item.term_first  = TERM_W'(act_first) * TERM_W'(w_first);
        q_item.term_second = TERM_W'(act_second) * TERM_W'(w_second);
        q_item.ws_first    = s_axis_tdata[39:24];
        q_item.ws_second   = s_axis_tdata[55:40];
        q_item.as_first    = s_axis_tdata[71:56];
        q_item.as_second   = s_axis_tdata[87:72];
        q_item.close_group = s_axis_tuser[0] | s_axis_tlast;
        q_item.dot_end     = s_axis_tlast;
    end

    assign s_axis_tready = !q_stat.full;
    assign q_push        = s_axis_tvalid && !q_stat.full;

endmodule
`default_nettype wire

@@ hdl/ibsdp_fifo.sv @@
// Short request queue between the front and the back end.
`default_nettype none
module ibsdp_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     push,
    input  wire ibsdp_pkg::ibsdp_item_t   push_item,
    input  wire logic                     pop,
    output ibsdp_pkg::ibsdp_item_t        pop_item,
    output logic                          pop_valid,
    output ibsdp_pkg::ibsdp_q_stat_t      stat
);
    import ibsdp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ibsdp_item_t            store_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_valid  = !stat.empty;
    assign pop_item   = store_reg[rd_ptr_reg];

    // Storage, no reset needed.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/ibsdp_back.sv @@
// Back end: block sums, scaling, saturating accumulator and result register.
`default_nettype none
module ibsdp_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  wire ibsdp_pkg::ibsdp_item_t      q_item,
    output logic                             q_pop,
    output logic [ibsdp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic [0:0]                       m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output ibsdp_pkg::ibsdp_back_stat_t      stat
);
    import ibsdp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_PROD,
        S_ACC1,
        S_ACC2,
        S_EMIT
    } state_t;

    state_t                       state_reg;
    logic signed [SUM_W-1:0]      sum_first_reg;
    logic signed [SUM_W-1:0]      sum_second_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic                         clip_reg;
    logic        [SCALE_W-1:0]    ws_first_reg;
    logic        [SCALE_W-1:0]    ws_second_reg;
    logic        [SCALE_W-1:0]    as_first_reg;
    logic        [SCALE_W-1:0]    as_second_reg;
    logic                         dot_end_reg;
    logic        [SCALE_PROD_W-1:0] sc_first_reg;
    logic        [SCALE_PROD_W-1:0] sc_second_reg;
    logic signed [PROD_W-1:0]     prod_first_reg;
    logic signed [PROD_W-1:0]     prod_second_reg;
    logic        [M_TDATA_W-1:0]  out_data_reg;
    logic                         out_sat_reg;
    logic                         out_valid_reg;

    logic signed [SUM_W:0]        sum_first_wide;
    logic signed [SUM_W:0]        sum_second_wide;
    logic signed [SUM_W-1:0]      sum_first_sat;
    logic signed [SUM_W-1:0]      sum_second_sat;
    logic                         sum_ovf;
    logic signed [PROD_W-1:0]     add_term;
    logic signed [ACC_W:0]        acc_wide;
    logic signed [ACC_W-1:0]      acc_sat;
    logic                         acc_ovf;
    logic                         out_free;

    // Block sum additions with saturation at the 18-bit signed range.
    always_comb begin
        sum_first_wide  = $signed({sum_first_reg[SUM_W-1], sum_first_reg})
                        + (SUM_W+1)'(q_item.term_first);
        sum_second_wide = $signed({sum_second_reg[SUM_W-1], sum_second_reg})
                        + (SUM_W+1)'(q_item.term_second);
        sum_first_sat   = sum_first_wide[SUM_W-1:0];
        sum_second_sat  = sum_second_wide[SUM_W-1:0];
        if (sum_first_wide[SUM_W] != sum_first_wide[SUM_W-1]) begin
            sum_first_sat = sum_first_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                  : {1'b0, {(SUM_W-1){1'b1}}};
        end
        if (sum_second_wide[SUM_W] != sum_second_wide[SUM_W-1]) begin
            sum_second_sat = sum_second_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                    : {1'b0, {(SUM_W-1){1'b1}}};
        end
        sum_ovf = (sum_first_wide[SUM_W] != sum_first_wide[SUM_W-1])
               || (sum_second_wide[SUM_W] != sum_second_wide[SUM_W-1]);
    end

    // Accumulator addition with saturation at the 64-bit signed limits.
    always_comb begin
        add_term = (state_reg == S_ACC1) ? prod_first_reg : prod_second_reg;
        acc_wide = $signed({acc_reg[ACC_W-1], acc_reg}) + (ACC_W+1)'(add_term);
        acc_ovf  = (acc_wide[ACC_W] != acc_wide[ACC_W-1]);
        if (acc_ovf) begin
            acc_sat = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = acc_wide[ACC_W-1:0];
        end
    end

    assign out_free       = !out_valid_reg || m_axis_tready;
    assign q_pop          = (state_reg == S_IDLE) && q_valid;
    assign m_axis_tdata   = out_data_reg;
    assign m_axis_tuser   = out_sat_reg;
    assign m_axis_tvalid  = out_valid_reg;
    assign stat.busy      = (state_reg != S_IDLE);
    assign stat.emit_wait = (state_reg == S_EMIT) && !out_free;

    // Sequencer, datapath registers and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            sum_first_reg  <= '0;
            sum_second_reg <= '0;
            acc_reg        <= '0;
            clip_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            // The result register is loaded from the emit state and cleared once taken.
            if ((state_reg == S_EMIT) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        sum_first_reg  <= sum_first_sat;
                        sum_second_reg <= sum_second_sat;
                        if (sum_ovf) begin
                            clip_reg <= 1'b1;
                        end
                        ws_first_reg  <= q_item.ws_first;
                        ws_second_reg <= q_item.ws_second;
                        as_first_reg  <= q_item.as_first;
                        as_second_reg <= q_item.as_second;
                        dot_end_reg   <= q_item.dot_end;
                        if (q_item.close_group) begin
                            state_reg <= S_SCALE;
                        end
                    end
                end
                S_SCALE: begin
                    sc_first_reg  <= ws_first_reg * as_first_reg;
                    sc_second_reg <= ws_second_reg * as_second_reg;
                    state_reg     <= S_PROD;
                end
                S_PROD: begin
                    prod_first_reg  <= PROD_W'(sum_first_reg) * $signed({1'b0, sc_first_reg});
                    prod_second_reg <= PROD_W'(sum_second_reg) * $signed({1'b0, sc_second_reg});
                    sum_first_reg   <= '0;
                    sum_second_reg  <= '0;
                    state_reg       <= S_ACC1;
                end
                S_ACC1: begin
                    acc_reg <= acc_sat;
                    if (acc_ovf) begin
                        clip_reg <= 1'b1;
                    end
                    state_reg <= S_ACC2;
                end
                S_ACC2: begin
                    acc_reg <= acc_sat;
                    if (acc_ovf) begin
                        clip_reg <= 1'b1;
                    end
                    state_reg <= dot_end_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_data_reg  <= acc_reg;
                        out_sat_reg   <= clip_reg;
                        acc_reg       <= '0;
                        clip_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hdl/int4_int8_block_scaled_dot_product.sv @@
// Top level of the block-scaled int4 x int8 dot product.
//
// Input stream s_axis: one request per weight byte. tdata carries the packed
// weight byte, both activations, the four 0.16 scales and both zero points;
// tuser[0] marks the last byte of a group pair and tlast the last byte of
// the dot product (which also closes the open group pair).
// Output stream m_axis: one result per dot product. tdata is the signed dot
// product with 32 fraction bits, tuser[0] tells whether any clip happened.
// A front end forms the nibble products and writes them into a queue of
// QUEUE_DEPTH entries; the back end works through the queue in order.
// In the back end a byte that closes no group only adds to the block sums;
// a group-closing byte then goes through the scale multiply, block-sum
// multiply and two saturating accumulator adds, and a dot-closing byte also
// loads the result register. The back end takes no new byte until it is
// through with a closing one; the queue lets the front take bytes while the
// back end is scaling.
// If the receiver stalls, the result register holds; one further dot product
// can complete behind it before the back end waits and the queue fills.
// Synchronous reset clears block sums, accumulator, queue and result valid.
`default_nettype none
`include "assert_macros.svh"
module int4_int8_block_scaled_dot_product #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // weight_byte[7:0], act_first[15:8], act_second[23:16],
    // weight_scale_first[39:24], weight_scale_second[55:40],
    // act_scale_first[71:56], act_scale_second[87:72],
    // zero_first[91:88], zero_second[95:92]
    input  wire logic [ibsdp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // group_end[0]
    input  wire logic [0:0]                     s_axis_tuser,
    input  wire logic                           s_axis_tlast,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // dot_value[63:0]
    output logic [ibsdp_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // saturated[0]
    output logic [0:0]                          m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready
);
    import ibsdp_pkg::*;

    ibsdp_q_stat_t    q_stat;
    ibsdp_back_stat_t back_stat;
    ibsdp_item_t      push_item;
    ibsdp_item_t      pop_item;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;

    // Request classification.
    ibsdp_front u_front (
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    // Queue between front and back.
    ibsdp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .pop_valid (q_valid),
        .stat      (q_stat)
    );

    // Accumulation and result delivery.
    ibsdp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (back_stat)
    );

    // The back end only takes from a queue that holds something.
    `ASSERT_IMPL(a_pop_not_empty, aclk, aresetn, q_pop, !q_stat.empty)
    // The front end never writes into a full queue.
    `ASSERT_IMPL(a_push_not_full, aclk, aresetn, q_push, !q_stat.full)
    // While scaling, multiplying, accumulating or emitting, nothing more is taken from the queue.
    `ASSERT_IMPL(a_no_pop_busy, aclk, aresetn, back_stat.busy, !q_pop)
    // A pending result waits for a stalled receiver.
    `ASSERT_NEXT(a_emit_waits, aclk, aresetn, back_stat.emit_wait, back_stat.busy)

endmodule
`default_nettype wire
